// ===== rtl/dgd_pkg.sv =====
// Shared types and constants of the dust-gas drag update block.
// Holds the channel payload structs, register indexes and fixed-point widths.
// Used by dgd_if.sv and dust_gas_drag_explicit_update_core.sv.
package dgd_pkg;

    localparam int DW  = 32;          // word width
    localparam int FB  = 16;          // fraction bits
    localparam int TW  = 31;          // unsigned field width
    localparam int CIW = 2;           // register index width

    localparam logic signed [DW-1:0] SMAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [TW-1:0]        ONE_Q = TW'(64'd1 << FB);

    localparam logic [CIW-1:0] CFG_DT = 2'd0;
    localparam logic [CIW-1:0] CFG_FB = 2'd1;
    localparam logic [CIW-1:0] CFG_EM = 2'd2;

    localparam logic [1:0] EM_NONE = 2'd0;
    localparam logic [1:0] EM_WORK = 2'd1;
    localparam logic [1:0] EM_DISS = 2'd2;

    localparam logic OP_GAS    = 1'b0;
    localparam logic OP_DUST   = 1'b1;
    localparam logic KIND_DUST = 1'b0;
    localparam logic KIND_GAS  = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [TW-1:0]        prim_density;
        logic signed [DW-1:0] prim_vel_x;
        logic signed [DW-1:0] prim_vel_y;
        logic signed [DW-1:0] prim_vel_z;
        logic [TW-1:0]        cons_density;
        logic signed [DW-1:0] cons_mom_x;
        logic signed [DW-1:0] cons_mom_y;
        logic signed [DW-1:0] cons_mom_z;
        logic [TW-1:0]        stop_time;
        logic signed [DW-1:0] gas_energy_in;
        logic                 last_species;
    } t_in;

    typedef struct packed {
        logic                 kind;
        logic signed [DW-1:0] new_mom_x;
        logic signed [DW-1:0] new_mom_y;
        logic signed [DW-1:0] new_mom_z;
        logic signed [DW-1:0] new_gas_energy;
        logic                 saturated;
        logic                 last_result;
    } t_out;

endpackage

// ===== rtl/dgd_if.sv =====
// Valid/ready channel interfaces of the dust-gas drag update block.
// Depends on dgd_pkg for the payload structs.
interface dgd_in_if;
    import dgd_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface dgd_out_if;
    import dgd_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/dust_gas_drag_explicit_update_core.sv =====
// Explicit Euler dust-gas drag update, one cell at a time, on a shared
// multiplier, adder and radix-2 reciprocal divider under a sequencer.
// Depends on dgd_pkg and the channel interfaces in dgd_if.sv.
//
// Usage: a gas transaction on i_in opens a cell and stores the gas state; it
// gives no result. Each dust transaction that follows gives one dust result
// on o_out; the dust transaction marked last (or the MAX_SPECIES-th of the
// cell) also gives the gas result right after the dust result is taken.
// Configuration (dt, feedback, energy mode) is written on i_cfg_* while idle;
// the user must keep to this, as the block itself does not enforce it.
// One item is handled at a time; i_in.ready is high only when idle.
// Steps per item: a gas item forms the gas momenta and one reciprocal and
// gives no result; a dust item takes the reciprocal of its stop time, then
// the drag terms per axis, with a further reciprocal and energy term under
// dissipation heating; the gas result applies the gas momentum update, with
// a further reciprocal and energy term under gas work.
// Synchronous active-low reset returns the gas state to density one and
// zero momentum, energy and force sums, and clears the configuration to
// dt 0, feedback on, no energy term. A stalled receiver holds the result
// in the output register and the block waits.
module dust_gas_drag_explicit_update_core #(
    parameter int MAX_SPECIES = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    dgd_in_if.sink                    i_in,
    dgd_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [dgd_pkg::CIW-1:0]   i_cfg_idx,
    input  logic [dgd_pkg::TW-1:0]    i_cfg_data
);
    import dgd_pkg::*;

    localparam int CW  = $clog2(MAX_SPECIES + 1);
    localparam int AW  = DW + FB + 2;
    localparam int DCW = $clog2(2 * FB + 1);
    localparam logic [CW-1:0]  MAXC   = CW'(MAX_SPECIES);
    localparam logic [DCW-1:0] DSTART = DCW'(2 * FB);
    localparam logic [1:0]     C_LAST = 2'd2;
    localparam logic signed [2*DW-1:0] WMAXL = (2*DW)'(SMAX);
    localparam logic signed [2*DW-1:0] WMINL = (2*DW)'(SMIN);

    typedef enum logic [25:0] {
        S_IDLE   = 26'h0000001,
        S_GPM    = 26'h0000002,
        S_GDIV   = 26'h0000004,
        S_DALPHA = 26'h0000008,
        S_DEPS   = 26'h0000010,
        S_DPD    = 26'h0000020,
        S_DT     = 26'h0000040,
        S_DDIFF  = 26'h0000080,
        S_DFORCE = 26'h0000100,
        S_DDM    = 26'h0000200,
        S_DNEWM  = 26'h0000400,
        S_DGFS   = 26'h0000800,
        S_DINV   = 26'h0001000,
        S_DFIN   = 26'h0002000,
        S_ODUST  = 26'h0004000,
        S_GDM    = 26'h0008000,
        S_GNEW   = 26'h0010000,
        S_GINV   = 26'h0020000,
        S_EVB    = 26'h0040000,
        S_EVA    = 26'h0080000,
        S_EACC   = 26'h0100000,
        S_EMAC   = 26'h0200000,
        S_ESAT   = 26'h0400000,
        S_EUPD   = 26'h0800000,
        S_GFIN   = 26'h1000000,
        S_OGAS   = 26'h2000000
    } t_state;

    function automatic logic [DW:0] clamp(input logic signed [2*DW-1:0] x);
        logic [DW:0] r;
        if (x > WMAXL)      r = {1'b1, SMAX};
        else if (x < WMINL) r = {1'b1, SMIN};
        else                r = {1'b0, x[DW-1:0]};
        return r;
    endfunction

    t_state r_state, n_state;
    logic [1:0] r_c;
    logic r_egas;

    logic [TW-1:0] r_dt;
    logic          r_fb;
    logic [1:0]    r_em;

    logic signed [DW-1:0] r_rho;
    logic signed [DW-1:0] r_vel [3];
    logic signed [DW-1:0] r_mom [3];
    logic [TW-1:0]        r_cden;
    logic                 r_last;

    logic signed [DW-1:0] r_ginv, r_gea;
    logic signed [DW-1:0] r_gpm [3];
    logic signed [DW-1:0] r_gcm [3];
    logic signed [DW-1:0] r_gfs [3];
    logic [TW-1:0]        r_gcden;
    logic                 r_gsat;
    logic [CW-1:0]        r_cnt, n_cnt;

    logic signed [DW-1:0] r_rcp, r_eps, r_pd, r_t, r_force, r_vb, r_vm;
    logic signed [DW-1:0] r_dm [3];
    logic signed [DW-1:0] r_newm [3];
    logic signed [AW-1:0] r_acc;
    logic                 r_f, r_lastd;

    logic [DW-1:0]  r_den, r_quo;
    logic [DW:0]    r_rem;
    logic [DCW-1:0] r_dcnt;

    t_out r_odata;

    // shared datapath
    logic signed [DW-1:0]   mul_a, mul_b, add_a, add_b, mul_q, add_q, acc_q, div_q;
    logic                   add_sub, mul_ovf, add_ovf, acc_ovf, div_ovf, div_done;
    logic signed [2*DW-1:0] prod, mul_sh;
    logic signed [DW:0]     sum;
    logic [DW:0]            rem_sh, rem_nx, q_fin;
    logic                   ge, e_flag_gas;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_GPM, S_DPD: begin mul_a = r_rho;        mul_b = r_vel[r_c]; end
            S_DEPS:       begin mul_a = r_rho;        mul_b = r_ginv; end
            S_DT:         begin mul_a = r_eps;        mul_b = r_gpm[r_c]; end
            S_DFORCE:     begin mul_a = r_rcp;        mul_b = r_t; end
            S_DDM:        begin mul_a = r_force;      mul_b = $signed({1'b0, r_dt}); end
            S_GDM:        begin mul_a = r_gfs[r_c];   mul_b = $signed({1'b0, r_dt}); end
            S_EVB:        begin
                mul_a = r_egas ? r_gcm[r_c] : r_mom[r_c];
                mul_b = r_rcp;
            end
            S_EVA:        begin mul_a = r_newm[r_c];  mul_b = r_rcp; end
            S_EMAC:       begin mul_a = r_dm[r_c];    mul_b = r_vm; end
            default: ;
        endcase
    end

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            S_DDIFF: begin add_a = r_t;         add_b = r_pd;       add_sub = 1'b1; end
            S_DNEWM: begin add_a = r_mom[r_c];  add_b = r_dm[r_c]; end
            S_GNEW:  begin add_a = r_gcm[r_c];  add_b = r_dm[r_c]; end
            S_DGFS:  begin add_a = r_gfs[r_c];  add_b = r_force;    add_sub = 1'b1; end
            S_EACC:  begin add_a = r_vb;        add_b = r_t; end
            S_EUPD:  begin add_a = r_gea;       add_b = r_t;        add_sub = !r_egas; end
            default: ;
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign mul_sh = prod >>> FB;
    assign {mul_ovf, mul_q} = clamp(mul_sh);
    assign sum    = add_sub ? ({add_a[DW-1], add_a} - {add_b[DW-1], add_b})
                            : ({add_a[DW-1], add_a} + {add_b[DW-1], add_b});
    assign {add_ovf, add_q} = clamp({{(DW-1){sum[DW]}}, sum});
    assign {acc_ovf, acc_q} = clamp({{(2*DW-AW){r_acc[AW-1]}}, r_acc});

    // one restoring step of 2^(2*FB) / r_den
    assign rem_sh   = {r_rem[DW-1:0], (r_dcnt == DSTART)};
    assign ge       = rem_sh >= {1'b0, r_den};
    assign rem_nx   = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
    assign q_fin    = {r_quo, ge};
    assign div_ovf  = q_fin[DW] | q_fin[DW-1];
    assign div_q    = div_ovf ? SMAX : $signed(q_fin[DW-1:0]);
    assign div_done = (r_dcnt == '0);

    assign e_flag_gas = r_egas;
    assign n_cnt = (r_cnt < MAXC) ? r_cnt + 1'b1 : r_cnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in.valid) n_state = (i_in.data.op == OP_GAS) ? S_GPM : S_DALPHA;
            S_GPM:    if (r_c == C_LAST) n_state = S_GDIV;
            S_GDIV:   if (div_done) n_state = S_IDLE;
            S_DALPHA: if (div_done) n_state = S_DEPS;
            S_DEPS:   n_state = S_DPD;
            S_DPD:    n_state = S_DT;
            S_DT:     n_state = S_DDIFF;
            S_DDIFF:  n_state = S_DFORCE;
            S_DFORCE: n_state = S_DDM;
            S_DDM:    n_state = S_DNEWM;
            S_DNEWM:  n_state = S_DGFS;
            S_DGFS: begin
                if (r_c != C_LAST)                   n_state = S_DPD;
                else if (r_fb && r_em == EM_DISS)    n_state = S_DINV;
                else                                 n_state = S_DFIN;
            end
            S_DINV:   if (div_done) n_state = S_EVB;
            S_DFIN:   n_state = S_ODUST;
            S_ODUST:  if (o_out.ready) n_state = r_lastd ? S_GDM : S_IDLE;
            S_GDM:    n_state = S_GNEW;
            S_GNEW: begin
                if (r_c != C_LAST)                   n_state = S_GDM;
                else if (r_fb && r_em == EM_WORK)    n_state = S_GINV;
                else                                 n_state = S_GFIN;
            end
            S_GINV:   if (div_done) n_state = S_EVB;
            S_EVB:    n_state = S_EVA;
            S_EVA:    n_state = S_EACC;
            S_EACC:   n_state = S_EMAC;
            S_EMAC:   n_state = (r_c == C_LAST) ? S_ESAT : S_EVB;
            S_ESAT:   n_state = S_EUPD;
            S_EUPD:   n_state = r_egas ? S_GFIN : S_DFIN;
            S_GFIN:   n_state = S_OGAS;
            S_OGAS:   if (o_out.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dt    <= '0;
            r_fb    <= 1'b1;
            r_em    <= EM_NONE;
            r_ginv  <= '0;
            r_gea   <= '0;
            r_gcden <= ONE_Q;
            r_gsat  <= 1'b0;
            r_cnt   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_gpm[i] <= '0;
                r_gcm[i] <= '0;
                r_gfs[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DT:  r_dt <= i_cfg_data;
                    CFG_FB:  r_fb <= i_cfg_data[0];
                    CFG_EM:  r_em <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            // divider iterates in every divide state
            if (r_state == S_GDIV || r_state == S_DALPHA ||
                r_state == S_DINV || r_state == S_GINV) begin
                r_rem  <= rem_nx;
                r_quo  <= q_fin[DW-1:0];
                r_dcnt <= r_dcnt - 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_rho   <= $signed({1'b0, i_in.data.prim_density});
                        r_vel[0] <= i_in.data.prim_vel_x;
                        r_vel[1] <= i_in.data.prim_vel_y;
                        r_vel[2] <= i_in.data.prim_vel_z;
                        r_mom[0] <= i_in.data.cons_mom_x;
                        r_mom[1] <= i_in.data.cons_mom_y;
                        r_mom[2] <= i_in.data.cons_mom_z;
                        r_cden  <= i_in.data.cons_density;
                        r_last  <= i_in.data.last_species;
                        r_c     <= '0;
                        r_f     <= 1'b0;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_dcnt  <= DSTART;
                        if (i_in.data.op == OP_GAS) begin
                            r_den    <= {1'b0, i_in.data.prim_density};
                            r_gcm[0] <= i_in.data.cons_mom_x;
                            r_gcm[1] <= i_in.data.cons_mom_y;
                            r_gcm[2] <= i_in.data.cons_mom_z;
                            for (int i = 0; i < 3; i++) r_gfs[i] <= '0;
                            r_gcden  <= i_in.data.cons_density;
                            r_gea    <= i_in.data.gas_energy_in;
                            r_cnt    <= '0;
                            r_gsat   <= 1'b0;
                        end else begin
                            r_den <= {1'b0, i_in.data.stop_time} + 1'b1;
                        end
                    end
                end
                S_GPM: begin
                    r_gpm[r_c] <= mul_q;
                    r_gsat     <= r_gsat | mul_ovf;
                    r_c        <= (r_c == C_LAST) ? '0 : r_c + 1'b1;
                end
                S_GDIV: begin
                    if (div_done) begin
                        r_ginv <= div_q;
                        r_gsat <= r_gsat | div_ovf;
                    end
                end
                S_DALPHA, S_DINV: begin
                    if (div_done) begin
                        r_rcp <= div_q;
                        r_f   <= r_f | div_ovf;
                    end
                end
                S_DEPS:   begin r_eps   <= mul_q; r_f <= r_f | mul_ovf; end
                S_DPD:    begin r_pd    <= mul_q; r_f <= r_f | mul_ovf; end
                S_DT:     begin r_t     <= mul_q; r_f <= r_f | mul_ovf; end
                S_DDIFF:  begin r_t     <= add_q; r_f <= r_f | add_ovf; end
                S_DFORCE: begin r_force <= mul_q; r_f <= r_f | mul_ovf; end
                S_DDM:    begin r_dm[r_c] <= mul_q; r_f <= r_f | mul_ovf; end
                S_DNEWM:  begin r_newm[r_c] <= add_q; r_f <= r_f | add_ovf; end
                S_DGFS: begin
                    if (r_fb) begin
                        r_gfs[r_c] <= add_q;
                        r_gsat     <= r_gsat | add_ovf;
                    end
                    r_c <= (r_c == C_LAST) ? '0 : r_c + 1'b1;
                    if (r_c == C_LAST) begin
                        // arm the divider for 1/cons_density
                        r_den  <= {1'b0, r_cden};
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_dcnt <= DSTART;
                        r_acc  <= '0;
                        r_egas <= 1'b0;
                    end
                end
                S_DFIN: begin
                    r_cnt   <= n_cnt;
                    r_lastd <= r_last || (n_cnt >= MAXC);
                    if (r_f && r_fb && r_em == EM_DISS) r_gsat <= 1'b1;
                    r_odata.kind           <= KIND_DUST;
                    r_odata.new_mom_x      <= r_newm[0];
                    r_odata.new_mom_y      <= r_newm[1];
                    r_odata.new_mom_z      <= r_newm[2];
                    r_odata.new_gas_energy <= '0;
                    r_odata.saturated      <= r_f;
                    r_odata.last_result    <= 1'b0;
                end
                S_ODUST: r_c <= '0;
                S_GDM: begin
                    r_dm[r_c] <= mul_q;
                    r_gsat    <= r_gsat | mul_ovf;
                end
                S_GNEW: begin
                    r_newm[r_c] <= add_q;
                    r_gsat      <= r_gsat | add_ovf;
                    r_c         <= (r_c == C_LAST) ? '0 : r_c + 1'b1;
                    if (r_c == C_LAST) begin
                        r_den  <= {1'b0, r_gcden};
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_dcnt <= DSTART;
                        r_acc  <= '0;
                        r_egas <= 1'b1;
                    end
                end
                S_GINV: begin
                    if (div_done) begin
                        r_rcp  <= div_q;
                        r_gsat <= r_gsat | div_ovf;
                    end
                end
                S_EVB, S_EVA: begin
                    if (r_state == S_EVB) r_vb <= mul_q;
                    else                  r_t  <= mul_q;
                    if (e_flag_gas) r_gsat <= r_gsat | mul_ovf;
                    else            r_f    <= r_f | mul_ovf;
                end
                S_EACC: r_vm <= sum[DW:1];
                S_EMAC: begin
                    r_acc <= r_acc + mul_sh[AW-1:0];
                    r_c   <= (r_c == C_LAST) ? '0 : r_c + 1'b1;
                end
                S_ESAT: begin
                    r_t <= acc_q;
                    if (e_flag_gas) r_gsat <= r_gsat | acc_ovf;
                    else            r_f    <= r_f | acc_ovf;
                end
                S_EUPD: begin
                    r_gea  <= add_q;
                    r_gsat <= r_gsat | add_ovf;
                end
                S_GFIN: begin
                    for (int i = 0; i < 3; i++) begin
                        r_gcm[i] <= r_newm[i];
                        r_gfs[i] <= '0;
                    end
                    r_odata.kind           <= KIND_GAS;
                    r_odata.new_mom_x      <= r_newm[0];
                    r_odata.new_mom_y      <= r_newm[1];
                    r_odata.new_mom_z      <= r_newm[2];
                    r_odata.new_gas_energy <= r_gea;
                    r_odata.saturated      <= r_gsat;
                    r_odata.last_result    <= 1'b1;
                    r_cnt  <= '0;
                    r_gsat <= 1'b0;
                end
                S_OGAS: ;
                default: ;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_ODUST) || (r_state == S_OGAS);
    assign o_out.data  = r_odata;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input accepted while a result is pending");
    a_gas_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.kind == KIND_GAS) |-> o_out.data.last_result)
        else $error("gas result not marked last");
    a_dust_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.kind == KIND_DUST) |->
            (o_out.data.new_gas_energy == '0 && !o_out.data.last_result))
        else $error("dust result carries energy or last mark");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAXC)
        else $error("species count out of range");
    a_cell_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.data.kind == KIND_GAS) |=>
            (r_cnt == '0 && !r_gsat))
        else $error("cell state not cleared after gas result");
`endif

endmodule
